// ===== rtl/core/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, round constants and the rotate helper of the hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } sha_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_word;    // Write one input transaction into the buffer.
        logic       pad_word;     // Write one padding word into the buffer.
        logic       start_block;  // Copy the chaining words into a..h.
        logic       round_en;     // Run one compression round.
        logic       fold;         // Add a..h into the chaining words.
        logic       reset_chain;  // Restore initial hash and clear length.
        logic       latch_final;  // Capture the final transaction's fields.
    } sha_cmd_t;

    // Status returned by the datapath.
    typedef struct packed {
        logic       block_full;   // The word being written now completes a block.
        logic       last_round;   // The current round is round 63.
        logic       pad_done;     // The padding has reached the length low word.
    } sha_stat_t;

    localparam logic [31:0] START_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] PAD_MARK = 32'h80000000;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sha256_datapath.sv =====
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, message schedule, round logic, chaining words and length.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_datapath
    import sha256_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire sha_cmd_t    cmd,
    input  wire logic [31:0] data_word,
    input  wire logic [2:0]  valid_bytes,
    input  wire logic [2:0]  emit_idx,
    output sha_stat_t        stat,
    output logic [31:0]      digest_out
);

    logic [31:0] chain_reg [8];
    logic [31:0] var_reg [8];
    logic [31:0] win_reg [16];
    logic [3:0]  fill_reg;
    logic [63:0] len_reg;
    logic [5:0]  round_reg;
    logic [31:0] final_data_reg;
    logic [2:0]  final_valid_reg;
    logic [1:0]  pad_phase_reg;  // 0: partial/marker word, 1: zeros, 2: len hi, 3: len lo
    logic        pad_mark_done_reg;

    logic [31:0] w_cur;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] pad_word_val;
    logic [2:0]  vb_clip;
    logic [63:0] len_final;
    logic [1:0]  pad_phase_next;
    logic        pad_mark_done_next;

    // The window rolls: round t reads its word at t mod 16.
    always_comb
    begin
        logic [31:0] w2;
        logic [31:0] w15;
        w2  = win_reg[4'(round_reg - 6'd2)];
        w15 = win_reg[4'(round_reg - 6'd15)];
        w_new = (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10))
              + win_reg[4'(round_reg - 6'd7)]
              + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3))
              + win_reg[round_reg[3:0]];
        w_cur = (round_reg < 6'd16) ? win_reg[round_reg[3:0]] : w_new;
    end

    always_comb
    begin
        t1 = var_reg[7]
           + (rotr(var_reg[4], 6) ^ rotr(var_reg[4], 11) ^ rotr(var_reg[4], 25))
           + ((var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]))
           + ROUND_K[round_reg] + w_cur;
        t2 = (rotr(var_reg[0], 2) ^ rotr(var_reg[0], 13) ^ rotr(var_reg[0], 22))
           + ((var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
              ^ (var_reg[1] & var_reg[2]));
    end

    assign vb_clip   = (final_valid_reg > 3'd4) ? 3'd4 : final_valid_reg;
    assign len_final = len_reg;

    // Padding sequence: after the final transaction, the next words are the
    // marker word (preceded by the plain data word when four bytes are valid), zero
    // fill to position 14, then the two length words.
    always_comb
    begin
        logic [31:0] keep;
        pad_word_val       = 32'd0;
        pad_phase_next     = pad_phase_reg;
        pad_mark_done_next = pad_mark_done_reg;
        keep               = 32'd0;
        case (pad_phase_reg)
            2'd0:
            begin
                if (vb_clip == 3'd4 && !pad_mark_done_reg)
                begin
                    pad_word_val       = final_data_reg;
                    pad_mark_done_next = 1'b1;
                end
                else if (vb_clip == 3'd4)
                begin
                    pad_word_val   = PAD_MARK;
                    pad_phase_next = (fill_reg == 4'd13) ? 2'd2 : 2'd1;
                end
                else
                begin
                    keep = (vb_clip == 3'd0) ? 32'd0 : (32'hffffffff << (6'd32 - 6'(vb_clip) * 6'd8));
                    pad_word_val   = (final_data_reg & keep)
                                   | (PAD_MARK >> (6'(vb_clip) * 6'd8));
                    pad_phase_next = (fill_reg == 4'd13) ? 2'd2 : 2'd1;
                end
            end
            2'd1:
            begin
                pad_word_val   = 32'd0;
                if (fill_reg == 4'd13)
                begin
                    pad_phase_next = 2'd2;
                end
            end
            2'd2:
            begin
                pad_word_val   = len_final[63:32];
                pad_phase_next = 2'd3;
            end
            default:
            begin
                // The phase stays here until the next final transaction so that
                // the controller sees the end of padding at the fold.
                pad_word_val   = len_final[31:0];
                pad_phase_next = 2'd3;
            end
        endcase
    end

    assign stat.block_full = (fill_reg == 4'd15);
    assign stat.last_round = (round_reg == 6'd63);
    assign stat.pad_done   = (pad_phase_reg == 2'd3);
    assign digest_out      = chain_reg[emit_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= START_H[i];
                var_reg[i]   <= 32'd0;
            end
            fill_reg          <= 4'd0;
            len_reg           <= 64'd0;
            round_reg         <= 6'd0;
            pad_phase_reg     <= 2'd0;
            pad_mark_done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_word)
            begin
                fill_reg <= fill_reg + 4'd1;
                len_reg  <= len_reg + 64'd32;
            end
            if (cmd.latch_final)
            begin
                len_reg <= len_reg
                         + {58'd0, ((valid_bytes > 3'd4) ? 3'd4 : valid_bytes), 3'd0};
                pad_phase_reg     <= 2'd0;
                pad_mark_done_reg <= 1'b0;
            end
            if (cmd.pad_word)
            begin
                fill_reg          <= fill_reg + 4'd1;
                pad_phase_reg     <= pad_phase_next;
                pad_mark_done_reg <= pad_mark_done_next;
            end
            if (cmd.start_block)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    var_reg[i] <= chain_reg[i];
                end
                round_reg <= 6'd0;
            end
            if (cmd.round_en)
            begin
                for (int i = 1; i < 8; i++)
                begin
                    if (i != 4)
                    begin
                        var_reg[i] <= var_reg[i - 1];
                    end
                end
                var_reg[4] <= var_reg[3] + t1;
                var_reg[0] <= t1 + t2;
                round_reg  <= round_reg + 6'd1;
            end
            if (cmd.fold)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + var_reg[i];
                end
            end
            if (cmd.reset_chain)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= START_H[i];
                end
                fill_reg <= 4'd0;
                len_reg  <= 64'd0;
            end
        end
    end

    // Block buffer and schedule window; every entry is written before it is read.
    always_ff @(posedge clk)
    begin
        if (cmd.load_word)
        begin
            win_reg[fill_reg] <= data_word;
        end
        else if (cmd.pad_word)
        begin
            win_reg[fill_reg] <= pad_word_val;
        end
        else if (cmd.round_en && round_reg >= 6'd16)
        begin
            win_reg[round_reg[3:0]] <= w_new;
        end
        if (cmd.latch_final)
        begin
            final_data_reg  <= data_word;
            final_valid_reg <= valid_bytes;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sha256_ctrl.sv =====
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences word loading, rounds, padding and digest output.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_ctrl
    import sha256_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_final,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    input  wire sha_stat_t stat,
    output sha_cmd_t       cmd,
    output logic [2:0]     emit_idx
);

    sha_state_t state_reg;
    sha_state_t state_next;
    logic       after_pad_reg;   // The running block came from padding.
    logic       after_pad_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       in_take;

    assign in_take  = in_valid && !in_stall;
    assign emit_idx = idx_reg;

    always_comb
    begin
        state_next     = state_reg;
        after_pad_next = after_pad_reg;
        idx_next       = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (in_final)
                    begin
                        state_next = ST_PAD;
                    end
                    else if (stat.block_full)
                    begin
                        state_next     = ST_ROUND;
                        after_pad_next = 1'b0;
                    end
                end
            end
            ST_ROUND:
            begin
                if (stat.last_round)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (after_pad_reg && stat.pad_done)
                begin
                    state_next = ST_EMIT;
                    idx_next   = 3'd0;
                end
                else if (after_pad_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                if (stat.block_full)
                begin
                    state_next     = ST_ROUND;
                    after_pad_next = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall        = 1'b0;
                cmd.load_word   = in_valid && !in_final;
                cmd.latch_final = in_valid && in_final;
                cmd.start_block = in_valid && !in_final && stat.block_full;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
            end
            ST_FOLD:
            begin
                cmd.fold = 1'b1;
            end
            ST_PAD:
            begin
                cmd.pad_word    = 1'b1;
                cmd.start_block = stat.block_full;
            end
            ST_EMIT:
            begin
                out_valid       = 1'b1;
                cmd.reset_chain = !out_stall && (idx_reg == 3'd7);
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            after_pad_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            state_reg     <= state_next;
            after_pad_reg <= after_pad_next;
            idx_reg       <= idx_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sha256_hash.sv =====
// ----------------------------------------------------------------------------
// SHA-256 hash engine
// Streams a message in 32-bit words and returns the eight digest words.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            fields
//  input    in         in_valid/in_stall    data_word, valid_bytes, final_word
//  output   out        out_valid/out_stall  digest_word, word_number, digest_last
//
//  A word that fills a block is accepted, then runs 64 rounds on one round
//  unit and one fold; other words need only the accept.
//  A final transaction is accepted, then for each of its one or two padding
//  blocks up to 16 buffer writes, 64 rounds and one fold follow; eight digest
//  words follow, one per cycle when the output does not stall.
//  Reset is asynchronous and active low; no clearing pass is needed.
//  A stall on the output holds the current digest word in place.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_hash
    import sha256_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] data_word,
    input  wire logic [2:0]  valid_bytes,
    input  wire logic        final_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_number,
    output logic             digest_last
);

    sha_cmd_t   cmd;
    sha_stat_t  stat;
    logic [2:0] emit_idx;

    sha256_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_final  (final_word),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd),
        .emit_idx  (emit_idx)
    );

    sha256_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_word   (data_word),
        .valid_bytes (valid_bytes),
        .emit_idx    (emit_idx),
        .stat        (stat),
        .digest_out  (digest_word)
    );

    assign word_number = emit_idx;
    assign digest_last = (emit_idx == 3'd7);

    // The engine never takes input while it shows a digest.
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("input taken during digest output");

    // A held digest word keeps its position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(word_number)))
        else $error("digest position moved under stall");

    // Rounds and buffer loads never overlap.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.round_en && (cmd.load_word || cmd.pad_word)))
        else $error("buffer written during rounds");

endmodule

`default_nettype wire
